FILE: hw/rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication not disabled by reset.
`define ASSERT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

FILE: hw/rtl/aabb_pkg.sv
// ----------------------------------------------------------------------------
// aabb_pkg
// Shared constants for the box collision response pipeline.
// ----------------------------------------------------------------------------
package aabb_pkg;

  // contact side codes
  localparam logic [1:0] SIDE_LEFT   = 2'd0;
  localparam logic [1:0] SIDE_RIGHT  = 2'd1;
  localparam logic [1:0] SIDE_TOP    = 2'd2;
  localparam logic [1:0] SIDE_BOTTOM = 2'd3;

  // signed 32-bit limits
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // width of an exact edge distance
  localparam int DIST_W = 34;

endpackage

FILE: hw/rtl/aabb_collision_resolve.sv
// ----------------------------------------------------------------------------
// aabb_collision_resolve
// Swept-box collision response for one pair of axis-aligned boxes.
// ----------------------------------------------------------------------------
// Takes one box pair per cycle (busy stays low) and returns one result per
// item, marked by done for one cycle. Most of the delay lies in the two
// contact-time dividers, which produce one quotient bit per stage over
// 33 + FRAC_BITS stages. Results cannot be held off and come out in input
// order.
module aabb_collision_resolve #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] pos_x_a,
  input  logic signed [31:0] pos_y_a,
  input  logic [30:0]        width_a,
  input  logic [30:0]        height_a,
  input  logic signed [31:0] vel_x_a,
  input  logic signed [31:0] vel_y_a,
  input  logic signed [31:0] pos_x_b,
  input  logic signed [31:0] pos_y_b,
  input  logic [30:0]        width_b,
  input  logic [30:0]        height_b,
  input  logic               handler_resolved,
  output logic               done,
  output logic               collided,
  output logic [1:0]         contact_side,
  output logic signed [31:0] new_pos_x,
  output logic signed [31:0] new_pos_y,
  output logic signed [31:0] new_vel_x,
  output logic signed [31:0] new_vel_y
);
  import aabb_pkg::*;

  `include "assert_macros.svh"

  localparam int DLAT = DIST_W - 1 + FRAC_BITS + 2;  // divider latency
  localparam int LAT  = DLAT + 5;                    // start sample to done sample

  typedef struct packed {
    logic               hit;
    logic               handled;
    logic               dx_neg;
    logic               dy_neg;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
  } pair_t;

  assign busy = 1'b0;

  // stage 0: input registers
  logic               v0;
  logic signed [31:0] xa, ya, vxa, vya, xb, yb;
  logic [30:0]        wa, ha, wb, hb;
  logic               hnd;

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else v0 <= start && !busy;
    xa <= pos_x_a;  ya <= pos_y_a;  wa <= width_a;  ha <= height_a;
    vxa <= vel_x_a; vya <= vel_y_a; xb <= pos_x_b;  yb <= pos_y_b;
    wb <= width_b;  hb <= height_b; hnd <= handler_resolved;
  end

  // stage 1: overlap test and contact distances
  logic signed [DIST_W-1:0] xa_e, ya_e, xb_e, yb_e;
  logic signed [DIST_W-1:0] xa_r, ya_r, xb_r, yb_r, dx_c, dy_c;
  logic                     hit_c;

  always_comb begin
    xa_e = DIST_W'(xa);
    ya_e = DIST_W'(ya);
    xb_e = DIST_W'(xb);
    yb_e = DIST_W'(yb);
    xa_r = xa_e + $signed({3'b000, wa});
    ya_r = ya_e + $signed({3'b000, ha});
    xb_r = xb_e + $signed({3'b000, wb});
    yb_r = yb_e + $signed({3'b000, hb});
    hit_c = !(xa_e >= xb_r || xa_r <= xb_e || ya_e >= yb_r || ya_r <= yb_e);
    dx_c = (vxa > 32'sd0) ? DIST_W'(xb_e - xa_r) : DIST_W'(xb_r - xa_e);
    dy_c = (vya > 32'sd0) ? DIST_W'(yb_e - ya_r) : DIST_W'(yb_r - ya_e);
  end

  logic                     v1;
  pair_t                    p1;
  logic signed [DIST_W-1:0] dx1, dy1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= v0;
    p1  <= '{hit: hit_c, handled: hnd, dx_neg: dx_c[DIST_W-1],
             dy_neg: dy_c[DIST_W-1], px: xa, py: ya, vx: vxa, vy: vya};
    dx1 <= dx_c;
    dy1 <= dy_c;
  end

  // contact-time dividers
  logic signed [31:0] tx, ty;

  aabb_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (.clk(clk), .span(dx1), .vel(p1.vx), .quot(tx));
  aabb_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (.clk(clk), .span(dy1), .vel(p1.vy), .quot(ty));

  // payload delay matching the dividers
  pair_t pd [1:DLAT];
  logic  vd [1:DLAT];

  always_ff @(posedge clk) begin
    pd[1] <= p1;
    if (rst) vd[1] <= 1'b0;
    else vd[1] <= v1;
  end

  for (genvar i = 2; i <= DLAT; i++) begin : g_delay
    always_ff @(posedge clk) begin
      pd[i] <= pd[i-1];
      if (rst) vd[i] <= 1'b0;
      else vd[i] <= vd[i-1];
    end
  end

  // stage 2: pick the later contact time
  logic               v2, xax2;
  pair_t              p2;
  logic signed [31:0] t2;
  logic [1:0]         side2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= vd[DLAT];
    p2   <= pd[DLAT];
    xax2 <= (tx > ty);
    t2   <= (tx > ty) ? tx : ty;
    if (tx > ty) side2 <= pd[DLAT].dx_neg ? SIDE_LEFT : SIDE_RIGHT;
    else side2 <= pd[DLAT].dy_neg ? SIDE_TOP : SIDE_BOTTOM;
  end

  // stage 3: displacement products
  logic               v3, xax3;
  pair_t              p3;
  logic [1:0]         side3;
  logic signed [63:0] mx3, my3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else v3 <= v2;
    p3    <= p2;
    xax3  <= xax2;
    side3 <= side2;
    mx3   <= 64'(p2.vx) * 64'(t2);
    my3   <= 64'(p2.vy) * 64'(t2);
  end

  // stage 4: move back, bounce, outputs
  logic signed [63:0] sx, sy;
  logic signed [31:0] nx_c, ny_c, nvx_c, nvy_c;

  always_comb begin
    sx = 64'(p3.px) + (mx3 >>> FRAC_BITS);
    sy = 64'(p3.py) + (my3 >>> FRAC_BITS);
    if (sx > 64'(S32_MAX)) nx_c = S32_MAX;
    else if (sx < 64'(S32_MIN)) nx_c = S32_MIN;
    else nx_c = sx[31:0];
    if (sy > 64'(S32_MAX)) ny_c = S32_MAX;
    else if (sy < 64'(S32_MIN)) ny_c = S32_MIN;
    else ny_c = sy[31:0];
    nvx_c = (p3.vx == S32_MIN) ? S32_MAX : 32'(-p3.vx);
    nvy_c = (p3.vy == S32_MIN) ? S32_MAX : 32'(-p3.vy);
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= v3;
    collided <= p3.hit;
    if (p3.hit) begin
      contact_side <= side3;
      new_pos_x    <= nx_c;
      new_pos_y    <= ny_c;
      new_vel_x    <= (!p3.handled && xax3) ? nvx_c : p3.vx;
      new_vel_y    <= (!p3.handled && !xax3) ? nvy_c : p3.vy;
    end else begin
      contact_side <= SIDE_LEFT;
      new_pos_x    <= p3.px;
      new_pos_y    <= p3.py;
      new_vel_x    <= p3.vx;
      new_vel_y    <= p3.vy;
    end
  end

  // checks
  `ASSERT_IMPL(a_done_lat, clk, rst, done, $past(start, LAT), "done without matching start")
  `ASSERT_IMPL(a_miss_side, clk, rst, done && !collided, contact_side == SIDE_LEFT, "side on miss")
  `ASSERT_ALWAYS(a_rst_clear, clk, $past(rst), !done, "done right after reset")

endmodule

FILE: hw/rtl/aabb_div.sv
// ----------------------------------------------------------------------------
// aabb_div
// Pipelined restoring divider: (span << FRAC_BITS) / vel, truncated toward
// zero, saturated to 32 bits; zero vel gives the minimum. One quotient bit
// per stage, one item per cycle.
// ----------------------------------------------------------------------------
module aabb_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic signed [aabb_pkg::DIST_W-1:0] span,
  input  logic signed [31:0]              vel,
  output logic signed [31:0]              quot
);
  import aabb_pkg::*;

  localparam int MW = DIST_W - 1;        // magnitude bits of a distance
  localparam int NW = MW + FRAC_BITS;    // dividend / quotient bits
  localparam int RW = 33;                // partial remainder bits

  logic [NW-1:0] num [0:NW];
  logic [NW-1:0] quo [0:NW];
  logic [RW-1:0] rem [0:NW];
  logic [31:0]   dvs [0:NW];
  logic          neg [0:NW];
  logic          zro [0:NW];

  logic [MW-1:0] span_abs;
  logic [32:0]   vel_abs;

  // operand magnitudes
  always_comb begin
    span_abs = span[DIST_W-1] ? MW'(-span) : MW'(span);
    vel_abs  = vel[31] ? 33'(-33'(vel)) : 33'(vel);
  end

  always_ff @(posedge clk) begin
    num[0] <= NW'(span_abs) << FRAC_BITS;
    quo[0] <= '0;
    rem[0] <= '0;
    dvs[0] <= vel_abs[31:0];
    neg[0] <= span[DIST_W-1] ^ vel[31];
    zro[0] <= (vel == 32'sd0);
  end

  // one quotient bit per stage
  for (genvar i = 1; i <= NW; i++) begin : g_stage
    logic [RW-1:0] trial;
    logic          take;
    always_comb begin
      trial = {rem[i-1][RW-2:0], num[i-1][NW-1]};
      take  = (trial >= {1'b0, dvs[i-1]});
    end
    always_ff @(posedge clk) begin
      rem[i] <= take ? RW'(trial - {1'b0, dvs[i-1]}) : trial;
      quo[i] <= {quo[i-1][NW-2:0], take};
      num[i] <= num[i-1] << 1;
      dvs[i] <= dvs[i-1];
      neg[i] <= neg[i-1];
      zro[i] <= zro[i-1];
    end
  end

  // sign and saturation
  always_ff @(posedge clk) begin
    if (zro[NW]) begin
      quot <= S32_MIN;
    end else if (neg[NW]) begin
      if (quo[NW] > NW'(33'h0_8000_0000)) quot <= S32_MIN;
      else quot <= 32'(-quo[NW][31:0]);
    end else begin
      if (quo[NW] > NW'(33'h0_7FFF_FFFF)) quot <= S32_MAX;
      else quot <= quo[NW][31:0];
    end
  end

endmodule

FILE: dv/tb_aabb_collision_resolve.sv
// ----------------------------------------------------------------------------
// tb_aabb_collision_resolve
// Self-checking bench for the box collision response pipeline.
// ----------------------------------------------------------------------------
// Box pairs go in through start/busy. A predictor in the bench computes each
// expected result, and results marked by done are checked in order against a
// queue of those predictions. Directed cases come first, then random pairs
// that mostly overlap, with random gaps between items but for one burst.
module tb_aabb_collision_resolve;
  import aabb_pkg::*;

  localparam int FRAC = 16;
  localparam int LATENCY = FRAC + 39;
  localparam int WATCHDOG = 4000;

  typedef struct packed {
    logic signed [31:0] xa;
    logic signed [31:0] ya;
    logic [30:0]        wa;
    logic [30:0]        ha;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] xb;
    logic signed [31:0] yb;
    logic [30:0]        wb;
    logic [30:0]        hb;
    logic               handled;
  } box_pair_t;

  typedef struct packed {
    logic               hit;
    logic [1:0]         side;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
  } response_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  box_pair_t pair = '0;
  logic done, collided;
  logic [1:0] contact_side;
  logic signed [31:0] new_pos_x, new_pos_y, new_vel_x, new_vel_y;

  response_t expected_responses[$];
  int errors = 0;
  int idle_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  aabb_collision_resolve #(.FRAC_BITS(FRAC)) i_dut (
    .clk, .rst, .start, .busy,
    .pos_x_a(pair.xa), .pos_y_a(pair.ya), .width_a(pair.wa), .height_a(pair.ha),
    .vel_x_a(pair.vx), .vel_y_a(pair.vy), .pos_x_b(pair.xb), .pos_y_b(pair.yb),
    .width_b(pair.wb), .height_b(pair.hb), .handler_resolved(pair.handled),
    .done, .collided, .contact_side, .new_pos_x, .new_pos_y, .new_vel_x, .new_vel_y
  );

  function automatic logic signed [63:0] clamp32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // contact time: (span << FRAC) / vel, toward zero, saturated
  function automatic logic signed [63:0] hit_time(logic signed [63:0] span,
                                                  logic signed [63:0] vel);
    logic signed [63:0] num;
    if (vel == 0) return -64'sd2147483648;
    num = span * (64'sd1 <<< FRAC);
    return clamp32(num / vel);
  endfunction

  // pos + floor(vel * t >> FRAC), saturated
  function automatic logic signed [63:0] slide(logic signed [63:0] pos,
                                               logic signed [63:0] vel,
                                               logic signed [63:0] t);
    logic signed [63:0] d;
    d = (vel == 0) ? 64'sd0 : ((vel * t) >>> FRAC);
    return clamp32(pos + d);
  endfunction

  function automatic response_t resolve_pair(box_pair_t p);
    response_t r;
    logic signed [63:0] xa, ya, wa, ha, vx, vy, xb, yb, wb, hb, dx, dy, tx, ty, t;
    logic x_axis;
    xa = 64'(p.xa); ya = 64'(p.ya); vx = 64'(p.vx); vy = 64'(p.vy);
    xb = 64'(p.xb); yb = 64'(p.yb);
    wa = {33'd0, p.wa}; ha = {33'd0, p.ha}; wb = {33'd0, p.wb}; hb = {33'd0, p.hb};
    r.px = p.xa; r.py = p.ya; r.vx = p.vx; r.vy = p.vy; r.side = SIDE_LEFT;
    r.hit = !(xa >= xb + wb || xa + wa <= xb || ya >= yb + hb || ya + ha <= yb);
    if (r.hit) begin
      dx = (vx > 0) ? xb - (xa + wa) : (xb + wb) - xa;
      dy = (vy > 0) ? yb - (ya + ha) : (yb + hb) - ya;
      tx = hit_time(dx, vx);
      ty = hit_time(dy, vy);
      x_axis = tx > ty;
      t = x_axis ? tx : ty;
      if (x_axis) r.side = (dx < 0) ? SIDE_LEFT : SIDE_RIGHT;
      else r.side = (dy < 0) ? SIDE_TOP : SIDE_BOTTOM;
      r.px = 32'(slide(xa, vx, t));
      r.py = 32'(slide(ya, vy, t));
      if (!p.handled) begin
        if (x_axis) r.vx = 32'(clamp32(-vx));
        else r.vy = 32'(clamp32(-vy));
      end
    end
    return r;
  endfunction

  // one item: optional gap with start low, then hold start until accepted
  task automatic send_pair(box_pair_t p, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pair <= p;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    expected_responses.insert(expected_responses.size(), resolve_pair(p));
    @(negedge clk);
  endtask

  task automatic send_gapped(box_pair_t p);
    send_pair(p, ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 17)));
  endtask

  function automatic logic [31:0] rnd_edge();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // fully random fields, including extreme values
  function automatic box_pair_t rnd_pair();
    box_pair_t p;
    p.xa = rnd_edge(); p.ya = rnd_edge(); p.vx = rnd_edge(); p.vy = rnd_edge();
    p.xb = rnd_edge(); p.yb = rnd_edge();
    p.wa = 31'(rnd_edge()); p.ha = 31'(rnd_edge());
    p.wb = 31'(rnd_edge()); p.hb = 31'(rnd_edge());
    p.handled = 1'($urandom_range(0, 1));
    return p;
  endfunction

  // overlapping pair: B is placed around A with random sizes and velocity
  function automatic box_pair_t rnd_overlap();
    box_pair_t p;
    int sh;
    sh = int'($urandom_range(4, 28));
    p = rnd_pair();
    p.xa = $signed($urandom) >>> $urandom_range(1, 8);
    p.ya = $signed($urandom) >>> $urandom_range(1, 8);
    p.wa = 31'(($urandom >> (32 - sh)) + 1);
    p.ha = 31'(($urandom >> (32 - sh)) + 1);
    p.wb = 31'(($urandom >> (32 - sh)) + 1);
    p.hb = 31'(($urandom >> (32 - sh)) + 1);
    p.xb = 32'(p.xa - $signed({1'b0, p.wb}) + 1 + ($urandom % (p.wa + p.wb - 1)));
    p.yb = 32'(p.ya - $signed({1'b0, p.hb}) + 1 + ($urandom % (p.ha + p.hb - 1)));
    if ($urandom_range(0, 7) == 0) p.vx = 0;
    else p.vx = $signed($urandom) >>> $urandom_range(0, 24);
    if ($urandom_range(0, 7) == 0) p.vy = 0;
    else p.vy = $signed($urandom) >>> $urandom_range(0, 24);
    return p;
  endfunction

  function automatic box_pair_t make_pair(int xa, int ya, int wa, int ha, int vx,
                                          int vy, int xb, int yb, int wb, int hb,
                                          bit h);
    box_pair_t p;
    p.xa = xa; p.ya = ya; p.wa = 31'(wa); p.ha = 31'(ha); p.vx = vx; p.vy = vy;
    p.xb = xb; p.yb = yb; p.wb = 31'(wb); p.hb = 31'(hb); p.handled = h;
    return p;
  endfunction

  // drop start and wait for every outstanding result
  task automatic wait_drained();
    start <= 1'b0;
    while (expected_responses.size() != 0) @(negedge clk);
  endtask

  // directed: each side, touching edges, zero velocity, ties, saturation
  task automatic test_directed();
    localparam int ONE = 32'h1_0000;
    localparam int MINV = 32'h8000_0000;
    localparam int MAXV = 32'h7FFF_FFFF;
    send_pair(make_pair(0, 0, 4*ONE, 4*ONE, ONE, 0, 3*ONE, 0, 4*ONE, 4*ONE, 0), 0);
    send_pair(make_pair(3*ONE, 0, 4*ONE, 4*ONE, -ONE, 0, 0, 0, 4*ONE, 4*ONE, 0), 0);
    send_pair(make_pair(0, 0, 4*ONE, 4*ONE, 0, ONE, 0, 3*ONE, 4*ONE, 4*ONE, 0), 0);
    send_pair(make_pair(0, 3*ONE, 4*ONE, 4*ONE, 0, -ONE, 0, 0, 4*ONE, 4*ONE, 1), 0);
    // edges touching only: no overlap
    send_pair(make_pair(0, 0, ONE, ONE, ONE, ONE, ONE, 0, ONE, ONE, 0), 1);
    send_pair(make_pair(0, 0, ONE, ONE, ONE, ONE, 0, ONE, ONE, ONE, 0), 0);
    // both velocities zero: tie goes to y
    send_pair(make_pair(0, 0, ONE, ONE, 0, 0, 0, 0, ONE, ONE, 0), 0);
    // equal times on both axes
    send_pair(make_pair(0, 0, 2*ONE, 2*ONE, ONE, ONE, ONE, ONE, 2*ONE, 2*ONE, 0), 0);
    // negating the minimum velocity
    send_pair(make_pair(0, 0, ONE, ONE, 0, MINV, 0, 0, ONE, ONE, 0), 0);
    send_pair(make_pair(0, 0, ONE, ONE, MINV, 1, 0, 0, ONE, ONE, 0), 0);
    // tiny velocity: quotient saturates
    send_pair(make_pair(MAXV - ONE, 0, MAXV, ONE, 1, 0, MINV, 0, MAXV, ONE, 0), 0);
    send_pair(make_pair(MINV, MINV, MAXV, MAXV, -1, -1, MINV, MINV, MAXV, MAXV, 0), 0);
    send_pair(make_pair(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV - 1, MAXV - 1,
                        MAXV, MAXV, 1), 0);
    send_pair(make_pair(MINV, MINV, 0, 0, 0, 0, MINV, MINV, 0, 0, 0), 0);
    send_pair(make_pair(0, 0, MAXV, MAXV, MINV, MAXV, 5, 5, 1, 1, 0), 0);
    send_pair(make_pair(-ONE, -ONE, 3*ONE, 3*ONE, -3, 7, 0, 0, ONE, ONE, 1), 0);
  endtask

  task automatic test_random_overlap(int n);
    repeat (n) send_gapped(rnd_overlap());
  endtask

  task automatic test_random_fields(int n);
    repeat (n) send_gapped(rnd_pair());
  endtask

  // back-to-back burst, then hold off until the pipeline is empty
  task automatic test_burst_and_drain(int n);
    repeat (n) send_pair(($urandom_range(0, 3) == 0) ? rnd_pair() : rnd_overlap(), 0);
    wait_drained();
  endtask

  // result checker: compare against the oldest prediction
  always @(posedge clk) begin
    response_t want;
    if (!rst && done) begin
      if (expected_responses.size() == 0) begin
        $display("%0t: unexpected result", $time);
        errors++;
      end else begin
        want = expected_responses.pop_front();
        if (collided !== want.hit) begin
          $display("%0t: collided exp %0d got %0d", $time, want.hit, collided);
          errors++;
        end
        if (contact_side !== want.side) begin
          $display("%0t: contact_side exp %0d got %0d", $time, want.side, contact_side);
          errors++;
        end
        if (new_pos_x !== want.px) begin
          $display("%0t: new_pos_x exp %0d got %0d", $time, want.px, new_pos_x);
          errors++;
        end
        if (new_pos_y !== want.py) begin
          $display("%0t: new_pos_y exp %0d got %0d", $time, want.py, new_pos_y);
          errors++;
        end
        if (new_vel_x !== want.vx) begin
          $display("%0t: new_vel_x exp %0d got %0d", $time, want.vx, new_vel_x);
          errors++;
        end
        if (new_vel_y !== want.vy) begin
          $display("%0t: new_vel_y exp %0d got %0d", $time, want.vy, new_vel_y);
          errors++;
        end
      end
    end
  end

  // watchdog: cycles with nothing accepted on either side
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_overlap(300);
    test_burst_and_drain(60);
    test_random_fields(150);
    test_random_overlap(120);
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && expected_responses.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/aabb_pkg.sv
hw/rtl/aabb_div.sv
hw/rtl/aabb_collision_resolve.sv
dv/tb_aabb_collision_resolve.sv
